[hw/rtl/base64_stream_encoder_core_assert.svh]
// Assertion macros for the encoder RTL, used by the back end.
// Defining NO_ASSERTIONS turns every check into nothing.
`ifndef BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`define BASE64_STREAM_ENCODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is held.
`define B64E_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also applies during reset.
`define B64E_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define B64E_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64E_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/b64e_pkg.sv]
// Shared types, constants and the alphabet lookup for the Base64 encoder.
// Depends on nothing; the front end, queue, back end, top level and testbench use it.
package b64e_pkg;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Position of the next byte within its three-byte group.
    typedef enum logic [1:0] {
        GRP_POS0 = 2'd0,
        GRP_POS1 = 2'd1,
        GRP_POS2 = 2'd2
    } t_grp_pos;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // Offsets that map an alphabet index onto its ASCII code.
    localparam logic [6:0] UPPER_BASE  = 7'h41;   // 'A'
    localparam logic [6:0] LOWER_OFFS  = 7'h47;   // 'a' - 26
    localparam logic [6:0] DIGIT_OFFS  = 7'h04;   // 52 - '0', subtracted
    localparam logic [6:0] PLUS_CHAR   = 7'h2B;
    localparam logic [6:0] SLASH_CHAR  = 7'h2F;
    localparam logic [5:0] LOWER_START = 6'd26;
    localparam logic [5:0] DIGIT_START = 6'd52;
    localparam logic [5:0] PLUS_INDEX  = 6'd62;

    // One classified byte: up to four characters for the back end.
    typedef struct packed {
        logic [3:0][5:0] sym;        // alphabet index per slot
        logic [3:0]      pad;        // slot carries '=' instead of a symbol
        logic [1:0]      last_slot;  // index of the final slot of this byte
    } t_job;

    // Write side of the job queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_wr;

    // Read side of the job queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_rd;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [6:0] b64_char(input logic [5:0] idx);
        logic [6:0] ch;
        if (idx < LOWER_START) begin
            ch = {1'b0, idx} + UPPER_BASE;
        end else if (idx < DIGIT_START) begin
            ch = {1'b0, idx} + LOWER_OFFS;
        end else if (idx < PLUS_INDEX) begin
            ch = {1'b0, idx} - DIGIT_OFFS;
        end else if (idx == PLUS_INDEX) begin
            ch = PLUS_CHAR;
        end else begin
            ch = SLASH_CHAR;
        end
        return ch;
    endfunction

endpackage

[hw/rtl/b64e_intf.sv]
// Valid/ready stream interfaces for the encoder's byte input and character output.
// Standalone; no package dependency.
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       end_of_run;

    modport source (output valid, output out_char, output end_of_run, input ready);
    modport sink   (input valid, input out_char, input end_of_run, output ready);
endinterface

[hw/rtl/b64e_front.sv]
// Front end: accepts bytes, tracks the group position and leftover bits,
// and turns each byte into a character job. Uses b64e_pkg and b64e_in_if.
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    b64e_in_if.sink             i_in,
    input  logic                i_q_full,
    output b64e_pkg::t_job_wr   o_push
);

    b64e_pkg::t_grp_pos r_pos, n_pos;
    logic [3:0]         r_carry, n_carry;
    b64e_pkg::t_job     w_job;
    logic               w_take;
    logic [7:0]         w_b;

    assign i_in.ready = !i_q_full;
    assign w_take     = i_in.valid && !i_q_full;
    assign w_b        = i_in.data_byte;

    // Classify the byte against the current group position.
    always_comb begin
        n_pos         = r_pos;
        n_carry       = r_carry;
        w_job.sym     = '0;
        w_job.pad     = '0;
        w_job.last_slot = 2'd0;
        unique case (r_pos)
            b64e_pkg::GRP_POS1: begin
                w_job.sym[0] = {r_carry[1:0], w_b[7:4]};
                if (i_in.last_byte) begin
                    w_job.sym[1]    = {w_b[3:0], 2'b00};
                    w_job.pad[2]    = 1'b1;
                    w_job.last_slot = 2'd2;
                    n_pos           = b64e_pkg::GRP_POS0;
                    n_carry         = 4'd0;
                end else begin
                    n_pos   = b64e_pkg::GRP_POS2;
                    n_carry = w_b[3:0];
                end
            end
            b64e_pkg::GRP_POS2: begin
                w_job.sym[0]    = {r_carry, w_b[7:6]};
                w_job.sym[1]    = w_b[5:0];
                w_job.last_slot = 2'd1;
                n_pos           = b64e_pkg::GRP_POS0;
                n_carry         = 4'd0;
            end
            default: begin
                // Group start; an unused position code behaves the same way.
                w_job.sym[0] = w_b[7:2];
                if (i_in.last_byte) begin
                    w_job.sym[1]    = {w_b[1:0], 4'b0000};
                    w_job.pad[2]    = 1'b1;
                    w_job.pad[3]    = 1'b1;
                    w_job.last_slot = 2'd3;
                    n_pos           = b64e_pkg::GRP_POS0;
                    n_carry         = 4'd0;
                end else begin
                    n_pos   = b64e_pkg::GRP_POS1;
                    n_carry = {2'b00, w_b[1:0]};
                end
            end
        endcase
    end

    assign o_push.valid = w_take;
    assign o_push.job   = w_job;

    // Group state advances only on an accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= b64e_pkg::GRP_POS0;
            r_carry <= 4'd0;
        end else if (w_take) begin
            r_pos   <= n_pos;
            r_carry <= n_carry;
        end
    end

endmodule

[hw/rtl/b64e_queue.sv]
// Small FIFO of character jobs between the front and back ends.
// Uses b64e_pkg for the job types.
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64e_pkg::t_job_wr  i_push,
    output logic               o_full,
    input  logic               i_pop,
    output b64e_pkg::t_job_rd  o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign w_push      = i_push.valid && !o_full;
    assign w_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    // Storage needs no reset; entries are read only after being written.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    // Pointers wrap at the configured depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/b64e_back.sv]
// Back end: walks each job slot by slot and drives one character per cycle,
// while the receiver is ready, through an output register. Uses b64e_pkg, b64e_out_if and the assert macros.
`include "base64_stream_encoder_core_assert.svh"

module b64e_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64e_pkg::t_job_rd  i_head,
    output logic               o_pop,
    b64e_out_if.source         o_out
);

    b64e_pkg::t_job r_job;
    logic [1:0]     r_slot;
    logic           r_active;
    logic           r_valid;
    logic [6:0]     r_char, n_char;
    logic           r_end, n_end;
    logic           w_load;
    logic           w_finish;

    // The output register may take a new character when empty or being drained.
    assign w_load   = !r_valid || o_out.ready;
    assign w_finish = r_active && w_load && (r_slot == r_job.last_slot);
    assign o_pop    = i_head.valid && (!r_active || w_finish);

    // Character for the current slot.
    always_comb begin
        n_end  = (r_slot == r_job.last_slot);
        n_char = r_job.pad[r_slot] ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(r_job.sym[r_slot]);
    end

    // Job and slot tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop) begin
            r_active <= 1'b1;
        end else if (w_finish) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_head.job;
            r_slot <= 2'd0;
        end else if (r_active && w_load) begin
            r_slot <= r_slot + 2'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && r_active) begin
            r_char <= n_char;
            r_end  <= n_end;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_char   = r_char;
    assign o_out.end_of_run = r_end;

    // A job never runs past its final slot.
    `B64E_ASSERT(a_slot_bound, i_clk, i_rst_n, !(r_active && (r_slot > r_job.last_slot)), "slot beyond last slot")
    // A pop always starts a fresh job at its first slot.
    `B64E_ASSERT(a_pop_start, i_clk, i_rst_n, o_pop |=> (r_active && (r_slot == 2'd0)), "pop did not start job")
    // Pops only happen against a non-empty queue.
    `B64E_ASSERT(a_pop_nonempty, i_clk, i_rst_n, o_pop |-> i_head.valid, "pop from empty queue")
    // Reset empties the output register.
    `B64E_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !r_valid, "output valid after reset")

endmodule

[hw/rtl/base64_stream_encoder_core.sv]
// Base64 stream encoder top level: front end, job queue and back end.
// A taken byte's job is written into the queue and loaded into the back end's job register,
// and its characters are then registered at the output, one character per cycle while
// the receiver is ready; a byte yields one to four characters.
// Reset (synchronous, active low) empties the queue and clears the group position.
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64e_in_if.sink      i_in,
    b64e_out_if.source   o_out
);

    b64e_pkg::t_job_wr w_push;
    b64e_pkg::t_job_rd w_head;
    logic              w_full;
    logic              w_pop;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    b64e_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_encoder_core: byte requests in, character requests out.
// Depends on b64e_pkg, the b64e_in_if / b64e_out_if interfaces and the encoder RTL.
module testbench;

    // One expected output character and its end-of-run flag.
    typedef struct packed {
        logic [6:0] out_char;
        logic       end_of_run;
    } t_enc_char;

    // Tracks the encoder's group state and holds the characters still owed by the block.
    class char_scoreboard;
        string               symbol_set =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        b64e_pkg::t_grp_pos  grp_pos = b64e_pkg::GRP_POS0;
        logic [3:0]          carry = 4'd0;
        t_enc_char           owed_chars[$];
        int                  mismatches = 0;
        int                  bytes_taken = 0;
        int                  messages_done = 0;
        int                  chars_checked = 0;

        function void owe_symbol(logic [5:0] idx, logic eor);
            t_enc_char c;
            c.out_char   = 7'(symbol_set[idx]);
            c.end_of_run = eor;
            owed_chars.push_back(c);
        endfunction

        function void owe_pad(logic eor);
            t_enc_char c;
            c.out_char   = b64e_pkg::PAD_CHAR;
            c.end_of_run = eor;
            owed_chars.push_back(c);
        endfunction

        function int pending();
            return owed_chars.size();
        endfunction

        // Predict the characters caused by one accepted byte request.
        function void note_byte(logic [7:0] b, logic last);
            bytes_taken++;
            if (last) messages_done++;
            case (grp_pos)
                b64e_pkg::GRP_POS1: begin
                    // A middle byte that is not last yields only this character.
                    owe_symbol({carry[1:0], b[7:4]}, !last);
                    carry = b[3:0];
                    if (last) begin
                        owe_symbol({carry, 2'b00}, 1'b0);
                        owe_pad(1'b1);
                        grp_pos = b64e_pkg::GRP_POS0;
                        carry   = 4'd0;
                    end else begin
                        grp_pos = b64e_pkg::GRP_POS2;
                    end
                end
                b64e_pkg::GRP_POS2: begin
                    // Third byte closes the group whether or not it is the last one.
                    owe_symbol({carry, b[7:6]}, 1'b0);
                    owe_symbol(b[5:0], 1'b1);
                    grp_pos = b64e_pkg::GRP_POS0;
                    carry   = 4'd0;
                end
                default: begin
                    carry = {2'b00, b[1:0]};
                    if (last) begin
                        owe_symbol(b[7:2], 1'b0);
                        owe_symbol({b[1:0], 4'b0000}, 1'b0);
                        owe_pad(1'b0);
                        owe_pad(1'b1);
                        grp_pos = b64e_pkg::GRP_POS0;
                        carry   = 4'd0;
                    end else begin
                        owe_symbol(b[7:2], 1'b1);
                        grp_pos = b64e_pkg::GRP_POS1;
                    end
                end
            endcase
        endfunction

        // Compare one accepted character request against the oldest owed character.
        function void check_char(logic [6:0] ch, logic eor);
            t_enc_char want;
            chars_checked++;
            if (owed_chars.size() == 0) begin
                $error("unexpected character: out_char %h, end_of_run %b", ch, eor);
                mismatches++;
                return;
            end
            want = owed_chars.pop_front();
            if (ch !== want.out_char) begin
                $error("out_char mismatch: expected %h, got %h", want.out_char, ch);
                mismatches++;
            end
            if (eor !== want.end_of_run) begin
                $error("end_of_run mismatch: expected %b, got %b", want.end_of_run, eor);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    char_scoreboard sb;

    b64e_in_if  in_bus();
    b64e_out_if out_bus();

    base64_stream_encoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Free-running clock, 2 ns period.
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver: decide ready at each falling edge, stalling at the phase's rate.
    always @(negedge clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted character request is checked at the rising edge.
    always @(posedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_char(out_bus.out_char, out_bus.end_of_run);
        end
    end

    // Offer one byte request, with a random idle gap first; returns at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        in_bus.last_byte <= last;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        sb.note_byte(b, last);
        @(negedge clk);
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Hold off the sender until every owed character has come out.
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int          idle_by_phase[4]  = '{0, 67, 0, 21};
        int          stall_by_phase[4] = '{0, 0, 67, 21};
        logic [7:0]  msg[$];
        int          phase_bytes;

        sb = new();
        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.data_byte  = 8'h00;
        in_bus.last_byte  = 1'b0;
        out_bus.ready     = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed messages: single bytes at both extremes, short groups, a full
        // group ending exactly on the last byte, the top two alphabet entries,
        // and a message that ends two bytes into its second group.
        send_message('{8'h00});
        send_message('{8'hFF});
        send_message('{8'h00, 8'hFF});
        send_message('{8'hFF, 8'h00});
        send_message('{8'hFB, 8'hEF, 8'hBE});
        send_message('{8'hFF, 8'hFF, 8'hFF});
        send_message('{8'h4D, 8'h61, 8'h6E});
        send_message('{8'h68, 8'h65, 8'h6C, 8'h6C, 8'h6F});
        wait_drained();

        // Random messages, one phase per idle/stall mix.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            phase_bytes    = 0;
            while (phase_bytes < 45) begin
                msg.delete();
                repeat (($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8))
                    msg.push_back(rand_byte());
                send_message(msg);
                phase_bytes += msg.size();
                // Early in each phase, let the output empty completely between messages.
                if (phase_bytes < 10) wait_drained();
            end
            wait_drained();
        end

        // Let any stray output show up before the verdict.
        repeat (10) @(negedge clk);
        $display("Covered %0d bytes in %0d messages and %0d characters over four idle/stall mixes.",
                 sb.bytes_taken, sb.messages_done, sb.chars_checked);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end
endmodule
